@@ hdl/tme_pkg.sv @@
// Shared types and constants of the truncated mean engine.
// Holds the transfer payload structs, register indexes and status codes.
// No dependencies.
package tme_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned MEAN_W      = 25;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned USED_W      = 7;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd1;

  localparam logic [FRAC_W-1:0] LOWER_RESET = 16'd0;
  localparam logic [FRAC_W-1:0] UPPER_RESET = 16'd22938;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } tme_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   segments_used;
  } tme_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BOUNDS,
    ST_HOLD_I,
    ST_CMP,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } tme_state_e;

endpackage

@@ hdl/truncated_mean_engine_unit.sv @@
// Truncated mean engine: collects a set of samples, ranks them, sums a rank
// window and divides by the scaled set size with a bit-serial divider.
// Depends on tme_pkg.
//
//   channel  direction  signals                             meaning
//   in       input      in_valid_i, in_stall_o, in_data_i    one sample per transfer
//   out      output     out_valid_o, out_stall_i, out_data_o one result per set
//   cfg      input      cfg_we_i, cfg_idx_i, cfg_data_i      rank fraction writes
//
// Samples load at one per cycle while the block is not busy. After the last
// sample the block works through bounds, ranking and divide: the single compare
// unit ranks each sample against all n, and the divider retires one quotient
// bit per cycle; an empty window skips ranking and divide.
// Reset clears the set and the output; the sample memory needs no clearing.
// The input stalls while busy; a pending result only blocks the next result.
module truncated_mean_engine_unit #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tme_pkg::tme_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tme_pkg::tme_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [tme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tme_pkg::FRAC_W-1:0]       cfg_data_i
);

  localparam int unsigned AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned D_W    = CNT_W + tme_pkg::FRAC_W;
  localparam int unsigned LO_W   = CNT_W + 1;
  localparam int unsigned HI_W   = D_W + 1 - tme_pkg::FRAC_BITS;
  localparam int unsigned SUM_W  = tme_pkg::SAMPLE_BITS + CNT_W;
  localparam int unsigned QW     = SUM_W + tme_pkg::FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(QW);

  tme_pkg::tme_state_e state_q, state_d;

  logic [CNT_W-1:0]                count_q, count_d;
  logic                            ovf_q, ovf_d;
  logic [tme_pkg::FRAC_W-1:0]      lower_q, upper_q;
  logic [LO_W-1:0]                 lo_q, lo_d;
  logic [CNT_W-1:0]                hi_q, hi_d;
  logic [D_W-1:0]                  d_q, d_d;
  logic                            empty_q, empty_d;
  logic [AW-1:0]                   i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [tme_pkg::SAMPLE_BITS-1:0] vi_q, vi_d;
  logic [SUM_W-1:0]                sum_q, sum_d;
  logic [QW-1:0]                   shreg_q, shreg_d;
  logic [D_W-1:0]                  rem_q, rem_d;
  logic [STEP_W-1:0]               step_q, step_d;
  logic                            out_valid_q, out_valid_d;
  tme_pkg::tme_out_t               out_data_q, out_data_d;

  logic [tme_pkg::SAMPLE_BITS-1:0] sample_mem_q [MAX_SEGMENTS];
  logic [tme_pkg::SAMPLE_BITS-1:0] rd_data_q;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;

  logic                            in_fire;
  logic [AW-1:0]                   last_idx;
  logic [D_W-1:0]                  prod_lo, prod_hi;
  logic [D_W:0]                    hi_round;
  logic [HI_W-1:0]                 hi_raw;
  logic [LO_W-1:0]                 lo_calc;
  logic [CNT_W-1:0]                hi_calc;
  logic                            rank_less;
  logic                            in_window;
  logic [SUM_W-1:0]                sum_acc;
  logic [D_W:0]                    rem_sh;
  logic                            rem_ge;
  logic [tme_pkg::MEAN_W-1:0]      mean_sat;

  assign in_stall_o  = (state_q != tme_pkg::ST_LOAD);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign wr_en       = in_fire && (count_q < CNT_W'(MAX_SEGMENTS));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign last_idx    = AW'(count_q - 1'b1);

  assign prod_lo  = D_W'(count_q) * D_W'(lower_q);
  assign prod_hi  = D_W'(count_q) * D_W'(upper_q);
  assign lo_calc  = LO_W'(prod_lo >> tme_pkg::FRAC_BITS);
  assign hi_round = {1'b0, prod_hi} + (D_W + 1)'((1 << tme_pkg::FRAC_BITS) - 1);
  assign hi_raw   = HI_W'(hi_round >> tme_pkg::FRAC_BITS);
  assign hi_calc  = (hi_raw > HI_W'(count_q)) ? count_q : CNT_W'(hi_raw);

  assign rank_less = (rd_data_q < vi_q) || ((rd_data_q == vi_q) && (j_q < i_q));
  assign in_window = (LO_W'(rank_q) >= lo_q) && (CNT_W'(rank_q) < hi_q);
  assign sum_acc   = in_window ? (sum_q + SUM_W'(vi_q)) : sum_q;

  assign rem_sh   = {rem_q, shreg_q[QW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, d_q});
  assign mean_sat = (|shreg_q[QW-1:tme_pkg::MEAN_W]) ? '1 : shreg_q[tme_pkg::MEAN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem_q[AW'(count_q)] <= in_data_i.sample;
    end
    rd_data_q <= sample_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= tme_pkg::LOWER_RESET;
      upper_q <= tme_pkg::UPPER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tme_pkg::CFG_LOWER: lower_q <= cfg_data_i;
        tme_pkg::CFG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tme_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    d_q        <= d_d;
    empty_q    <= empty_d;
    i_q        <= i_d;
    j_q        <= j_d;
    rank_q     <= rank_d;
    vi_q       <= vi_d;
    sum_q      <= sum_d;
    shreg_q    <= shreg_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    d_d         = d_q;
    empty_d     = empty_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    vi_d        = vi_q;
    sum_d       = sum_q;
    shreg_d     = shreg_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = '0;

    case (state_q)
      tme_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (wr_en) begin
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            state_d = tme_pkg::ST_BOUNDS;
          end
        end
      end
      tme_pkg::ST_BOUNDS: begin
        lo_d    = lo_calc;
        hi_d    = hi_calc;
        d_d     = prod_hi;
        empty_d = (prod_hi == '0) || (lo_calc >= LO_W'(hi_calc));
        i_d     = '0;
        sum_d   = '0;
        state_d = ((prod_hi == '0) || (lo_calc >= LO_W'(hi_calc))) ?
                  tme_pkg::ST_DONE : tme_pkg::ST_HOLD_I;
      end
      tme_pkg::ST_HOLD_I: begin
        vi_d    = rd_data_q;
        j_d     = '0;
        rank_d  = '0;
        state_d = tme_pkg::ST_CMP;
      end
      tme_pkg::ST_CMP: begin
        rd_addr = AW'(j_q + 1'b1);
        if (rank_less) begin
          rank_d = rank_q + 1'b1;
        end
        j_d = AW'(j_q + 1'b1);
        if (j_q == last_idx) begin
          state_d = tme_pkg::ST_ACC;
        end
      end
      tme_pkg::ST_ACC: begin
        rd_addr = AW'(i_q + 1'b1);
        sum_d   = sum_acc;
        i_d     = AW'(i_q + 1'b1);
        if (i_q == last_idx) begin
          shreg_d = {sum_acc, {tme_pkg::FRAC_BITS{1'b0}}};
          rem_d   = '0;
          step_d  = '0;
          state_d = tme_pkg::ST_DIV;
        end else begin
          state_d = tme_pkg::ST_HOLD_I;
        end
      end
      tme_pkg::ST_DIV: begin
        rem_d   = rem_ge ? D_W'(rem_sh - {1'b0, d_q}) : rem_sh[D_W-1:0];
        shreg_d = {shreg_q[QW-2:0], rem_ge};
        step_d  = step_q + 1'b1;
        if (step_q == STEP_W'(QW - 1)) begin
          state_d = tme_pkg::ST_DONE;
        end
      end
      tme_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_data_d.mean          = empty_q ? '0 : mean_sat;
          out_data_d.status        = empty_q ? tme_pkg::STATUS_EMPTY :
                                     (ovf_q ? tme_pkg::STATUS_DROP : tme_pkg::STATUS_OK);
          out_data_d.segments_used = tme_pkg::USED_W'(count_q);
          count_d                  = '0;
          ovf_d                    = 1'b0;
          state_d                  = tme_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = tme_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ tb/truncated_mean_engine_unit_tb.sv @@
// Testbench for truncated_mean_engine_unit: sends sample sets over the valid/stall
// input channel, predicts each truncated mean and compares every result transfer.
// Depends on tme_pkg and the engine RTL.
module truncated_mean_engine_unit_tb;

  localparam int unsigned MAX_SEG = 64;
  localparam longint unsigned MEAN_MAX = (64'd1 << tme_pkg::MEAN_W) - 64'd1;
  localparam logic [tme_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int BUSY_MAX = 2 + MAX_SEG * (MAX_SEG + 2) + tme_pkg::SAMPLE_BITS + 7 + 15;
  localparam int SETTLE = 16;
  localparam int RANDOM_ITEMS = 620;
  localparam int TOTAL_ITEMS = 720;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tme_pkg::tme_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tme_pkg::tme_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [tme_pkg::CFG_IDX_W-1:0] cfg_idx_i = tme_pkg::CFG_LOWER;
  logic [tme_pkg::FRAC_W-1:0] cfg_data_i = '0;

  // Shadow of the engine: current set, drop flag and rank fractions.
  logic [tme_pkg::SAMPLE_BITS-1:0] set_mem [MAX_SEG];
  int unsigned set_n = 0;
  bit drop_seen = 1'b0;
  logic [tme_pkg::FRAC_W-1:0] lower_frac = tme_pkg::LOWER_RESET;
  logic [tme_pkg::FRAC_W-1:0] upper_frac = tme_pkg::UPPER_RESET;
  tme_pkg::tme_out_t pending_means[$];

  bit idle_en = 1'b1;
  int fail_count = 0;
  int items_sent = 0;
  int sets_closed = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  truncated_mean_engine_unit #(
    .MAX_SEGMENTS(MAX_SEG)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic tme_pkg::tme_out_t truncated_mean();
    logic [tme_pkg::SAMPLE_BITS-1:0] ranked [MAX_SEG];
    logic [tme_pkg::SAMPLE_BITS-1:0] v;
    longint unsigned n, lo, hi, d, acc, q;
    int i, j;
    tme_pkg::tme_out_t r;
    n = set_n;
    for (i = 0; i < set_n; i++) begin
      v = set_mem[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    lo = (n * lower_frac) >> tme_pkg::FRAC_BITS;
    d = n * upper_frac;
    hi = (d + ((64'd1 << tme_pkg::FRAC_BITS) - 64'd1)) >> tme_pkg::FRAC_BITS;
    if (hi > n) hi = n;
    r.segments_used = n[tme_pkg::USED_W-1:0];
    if (d == 0 || lo >= hi) begin
      r.mean = '0;
      r.status = tme_pkg::STATUS_EMPTY;
    end else begin
      acc = 0;
      for (i = int'(lo); i < int'(hi); i++) acc += ranked[i];
      q = (acc << tme_pkg::FRAC_BITS) / d;
      if (q > MEAN_MAX) q = MEAN_MAX;
      r.mean = q[tme_pkg::MEAN_W-1:0];
      r.status = drop_seen ? tme_pkg::STATUS_DROP : tme_pkg::STATUS_OK;
    end
    return r;
  endfunction

  function automatic void load_sample(input tme_pkg::tme_in_t item);
    if (set_n < MAX_SEG) begin
      set_mem[set_n] = item.sample;
      set_n++;
    end else begin
      drop_seen = 1'b1;
    end
    if (item.last) begin
      pending_means.push_back(truncated_mean());
      set_n = 0;
      drop_seen = 1'b0;
      sets_closed++;
    end
  endfunction

  // Valid stays high from one transfer to the next unless a gap is drawn.
  task automatic send_sample(input logic [tme_pkg::SAMPLE_BITS-1:0] s, input logic l);
    tme_pkg::tme_in_t item;
    item.sample = s;
    item.last = l;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    load_sample(item);
    items_sent++;
  endtask

  function automatic logic [tme_pkg::SAMPLE_BITS-1:0] rand_sample();
    logic [tme_pkg::SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: s = SAMPLE_MAX;
      1: s = '0;
      2, 3: s = tme_pkg::SAMPLE_BITS'($urandom_range(0, 255));
      default: s = tme_pkg::SAMPLE_BITS'($urandom());
    endcase
    return s;
  endfunction

  task automatic send_set(input int count);
    int k;
    for (k = 0; k < count; k++) send_sample(rand_sample(), k == count - 1);
  endtask

  // Hold the input until every expected mean has been returned.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tme_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tme_pkg::FRAC_W-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tme_pkg::CFG_LOWER) lower_frac = val;
    else upper_frac = val;
    cfg_writes++;
  endtask

  function automatic logic [tme_pkg::FRAC_W-1:0] rand_frac(input bit is_upper);
    logic [tme_pkg::FRAC_W-1:0] f;
    case ($urandom_range(0, 9))
      0: f = '0;
      1: f = 16'd32768;
      2: f = '1;
      3: f = tme_pkg::FRAC_W'($urandom_range(0, 65535));
      default: f = is_upper ? tme_pkg::FRAC_W'($urandom_range(16384, 32768)) :
                              tme_pkg::FRAC_W'($urandom_range(0, 12000));
    endcase
    return f;
  endfunction

  function automatic int rand_set_size();
    int r, sz;
    r = $urandom_range(0, 19);
    if (r == 0) sz = $urandom_range(MAX_SEG + 1, MAX_SEG + 6);
    else if (r < 4) sz = $urandom_range(9, MAX_SEG);
    else sz = $urandom_range(1, 8);
    return sz;
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tme_pkg::tme_out_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d means pending",
                 quiet_cycles, pending_means.size());
        $display("truncated_mean_engine_unit_tb: FAIL");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_means.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: mean=%0d status=%0d used=%0d",
                     out_data_o.mean, out_data_o.status, out_data_o.segments_used);
        end else begin
          want = pending_means.pop_front();
          if (out_data_o.mean !== want.mean || out_data_o.status !== want.status ||
              out_data_o.segments_used !== want.segments_used) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch on result %0d: expected mean=%0d status=%0d used=%0d,",
                        " got mean=%0d status=%0d used=%0d"},
                       results_seen, want.mean, want.status, want.segments_used,
                       out_data_o.mean, out_data_o.status, out_data_o.segments_used);
          end
        end
      end
    end
  end

  task automatic test_single_sets();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b1);
    send_sample(24'd5, 1'b0);
    send_sample(24'd1, 1'b0);
    send_sample(24'd9, 1'b0);
    send_sample(24'd3, 1'b1);
  endtask

  task automatic test_window_edges();
    write_reg(tme_pkg::CFG_UPPER, 16'd32768);
    send_set(3);
    write_reg(tme_pkg::CFG_LOWER, 16'd32768);
    send_set(2);
    write_reg(tme_pkg::CFG_LOWER, '0);
    write_reg(tme_pkg::CFG_UPPER, '0);
    send_set(2);
    write_reg(tme_pkg::CFG_UPPER, '1);
    write_reg(tme_pkg::CFG_LOWER, '1);
    send_set(3);
    write_reg(tme_pkg::CFG_LOWER, 16'd16384);
    send_set(4);
  endtask

  task automatic test_saturation();
    write_reg(tme_pkg::CFG_LOWER, '0);
    write_reg(tme_pkg::CFG_UPPER, 16'd1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  task automatic test_overflow();
    int k;
    write_reg(tme_pkg::CFG_UPPER, 16'd32768);
    send_set(MAX_SEG);
    for (k = 0; k < MAX_SEG + 2; k++) send_sample(rand_sample(), k == MAX_SEG + 1);
    write_reg(tme_pkg::CFG_UPPER, '0);
    send_set(MAX_SEG + 1);
  endtask

  task automatic test_random_phases();
    int k, sets;
    while (items_sent < RANDOM_ITEMS) begin
      write_reg(tme_pkg::CFG_LOWER, rand_frac(1'b0));
      write_reg(tme_pkg::CFG_UPPER, rand_frac(1'b1));
      idle_en = ($urandom_range(0, 3) != 0);
      sets = $urandom_range(4, 10);
      for (k = 0; k < sets && items_sent < RANDOM_ITEMS; k++) send_set(rand_set_size());
    end
  endtask

  task automatic test_back_to_back();
    write_reg(tme_pkg::CFG_LOWER, 16'd3277);
    write_reg(tme_pkg::CFG_UPPER, tme_pkg::UPPER_RESET);
    idle_en = 1'b0;
    while (items_sent < TOTAL_ITEMS) send_set($urandom_range(1, 12));
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_single_sets();
    test_window_edges();
    test_saturation();
    test_overflow();
    test_random_phases();
    test_back_to_back();
    wait_idle();
    repeat (BUSY_MAX) @(negedge clk_i);
    $display("covered %0d sets from %0d samples under %0d register writes;",
             sets_closed, items_sent, cfg_writes);
    $display("checked %0d means with %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && pending_means.size() == 0) begin
      $display("truncated_mean_engine_unit_tb: PASS");
    end else begin
      $display("truncated_mean_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
